[rtl/core/string_to_int_any_base_assert.svh]
// Assertion macros used by the stoi_checker file.
`ifndef STRING_TO_INT_ANY_BASE_ASSERT_SVH
`define STRING_TO_INT_ANY_BASE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STOI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stoi assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STOI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stoi assertion failed");

`endif

[rtl/core/stoi_pkg.sv]
`timescale 1ns / 1ps

package stoi_pkg;

	localparam int NUM_SYM   = 16;
	localparam int SYM_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;
	localparam int BSIZE_W   = 5;
	localparam int DIG_W     = 4;
	localparam int VAL_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE  = 2'd2;

	localparam logic [SYM_W-1:0] CHR_NUL   = 8'h00;
	localparam logic [SYM_W-1:0] CHR_TAB   = 8'h09;
	localparam logic [SYM_W-1:0] CHR_LF    = 8'h0A;
	localparam logic [SYM_W-1:0] CHR_VT    = 8'h0B;
	localparam logic [SYM_W-1:0] CHR_FF    = 8'h0C;
	localparam logic [SYM_W-1:0] CHR_CR    = 8'h0D;
	localparam logic [SYM_W-1:0] CHR_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] CHR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHR_MINUS = 8'h2D;

	localparam logic [BSIZE_W-1:0] MIN_BASE = 5'd2;

	function automatic logic is_ws(input logic [SYM_W-1:0] c);
		return (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_VT) || (c == CHR_FF) ||
			(c == CHR_CR) || (c == CHR_SPACE);
	endfunction

endpackage

[rtl/core/string_to_int_any_base.sv]
// Number string parser with a configurable digit alphabet.
// Input channel (in_valid/in_ready): one character per item on chr, with
// last marking the final character of a string. Leading whitespace is
// skipped, then a run of +/- signs (each minus flips the sign), then digits
// are accumulated as acc*base + index until the first non-digit.
// Output channel (out_valid/out_ready): one item per string, given for the
// item marked last: value (wraps modulo 2^32) and base_ok; value is 0 when
// the alphabet is not a valid base.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write symbols_lo, symbols_hi
// and base_size; write only while the block is idle.
// Timing: an item is registered at acceptance and processed from there; a
// last item's result is then registered and raises out_valid. One item per
// cycle is taken unless a last item waits on a held result; the one-step
// multiply-add on the accumulator sets that figure.
// Stall: a waiting result does not block the input, except that a second
// last item is held in the input register until the result is taken.
// Reset clears all configuration, the parse state and both valid flags.
`timescale 1ns / 1ps

module string_to_int_any_base #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [stoi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stoi_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [stoi_pkg::SYM_W-1:0]         chr,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [stoi_pkg::VAL_W-1:0]  value,
	output logic                               base_ok
);
	import stoi_pkg::*;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_SIGN,
		PH_DIGIT,
		PH_DONE
	} phase_t;

	logic [CFG_W-1:0]   symbols_lo_q;
	logic [CFG_W-1:0]   symbols_hi_q;
	logic [BSIZE_W-1:0] base_size_q;

	logic               valid_s1;
	logic [SYM_W-1:0]   chr_s1;
	logic               last_s1;
	logic               advance;

	phase_t             phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [VAL_W-1:0]   acc_q, acc_d;

	logic               out_valid_q;
	logic [VAL_W-1:0]   value_q;
	logic               base_ok_q;

	logic [SYM_W-1:0]   sym [NUM_SYM];
	logic [BSIZE_W-1:0] used_n;
	logic               hit;
	logic [DIG_W-1:0]   dig;
	logic               ok;
	logic [VAL_W+BSIZE_W-1:0] prod;
	logic [VAL_W-1:0]   mag;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbols_lo_q <= '0;
			symbols_hi_q <= '0;
			base_size_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SYMBOLS_LO: symbols_lo_q <= cfg_wdata;
				REG_SYMBOLS_HI: symbols_hi_q <= cfg_wdata;
				REG_BASE_SIZE:  base_size_q  <= cfg_wdata[BSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SYM / 2; i++) begin
			sym[i]               = symbols_lo_q[i*SYM_W +: SYM_W];
			sym[i + NUM_SYM / 2] = symbols_hi_q[i*SYM_W +: SYM_W];
		end
	end

	assign used_n = (base_size_q > BSIZE_W'(MAX_SYMBOLS)) ? BSIZE_W'(MAX_SYMBOLS) : base_size_q;

	// alphabet check: size range, forbidden symbols, pairwise duplicates
	always_comb begin
		ok = (base_size_q >= MIN_BASE) && (base_size_q <= BSIZE_W'(MAX_SYMBOLS));
		for (int i = 0; i < NUM_SYM; i++) begin
			if (BSIZE_W'(i) < base_size_q) begin
				if (sym[i] == CHR_NUL || is_ws(sym[i]) || sym[i] == CHR_PLUS ||
						sym[i] == CHR_MINUS)
					ok = 1'b0;
				for (int j = i + 1; j < NUM_SYM; j++) begin
					if (BSIZE_W'(j) < base_size_q && sym[j] == sym[i])
						ok = 1'b0;
				end
			end
		end
	end

	// first matching symbol wins
	always_comb begin
		hit = 1'b0;
		dig = '0;
		for (int i = NUM_SYM - 1; i >= 0; i--) begin
			if (BSIZE_W'(i) < used_n && sym[i] == chr_s1) begin
				hit = 1'b1;
				dig = DIG_W'(i);
			end
		end
	end

	assign prod = {{BSIZE_W{1'b0}}, acc_q} * {{VAL_W{1'b0}}, base_size_q};

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		if (phase_d == PH_SKIP && !is_ws(chr_s1))
			phase_d = PH_SIGN;
		if (phase_d == PH_SIGN) begin
			if (chr_s1 == CHR_MINUS)
				neg_d = !neg_q;
			else if (chr_s1 != CHR_PLUS)
				phase_d = PH_DIGIT;
		end
		if (phase_d == PH_DIGIT) begin
			if (!hit)
				phase_d = PH_DONE;
			else
				acc_d = prod[VAL_W-1:0] + {{(VAL_W-DIG_W){1'b0}}, dig};
		end
	end

	assign mag = neg_d ? (VAL_W'(0) - acc_d) : acc_d;

	// a last item needs a free output register; other items always move on
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !advance);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			chr_s1  <= chr;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && !(advance && last_s1))
				out_valid_q <= 1'b0;
			if (advance) begin
				if (last_s1) begin
					phase_q     <= PH_SKIP;
					neg_q       <= 1'b0;
					acc_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					phase_q <= phase_d;
					neg_q   <= neg_d;
					acc_q   <= acc_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			value_q   <= ok ? mag : '0;
			base_ok_q <= ok;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = signed'(value_q);
	assign base_ok   = base_ok_q;

endmodule

[rtl/core/stoi_checker.sv]
`timescale 1ns / 1ps
`include "string_to_int_any_base_assert.svh"

module stoi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [31:0] value,
	input logic              base_ok
);

	// a stalled result holds
	`STOI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(value) && $stable(base_ok))

	// an invalid alphabet always reports zero
	`STOI_ASSERT_IMP(a_bad_base_zero, clk, arst_n, out_valid && !base_ok, value == 32'sd0)

	// input only backs up behind a result that is not taken
	`STOI_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind string_to_int_any_base stoi_checker u_stoi_checker (.*);

[verif/stoi_parse_checker.sv]
`timescale 1ns / 1ps

module stoi_parse_checker #(
	parameter int MAX_SYM = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [stoi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stoi_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [stoi_pkg::SYM_W-1:0]         chr,
	input  logic                               last,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [stoi_pkg::VAL_W-1:0]  value,
	input  logic                               base_ok,
	output int                                 fail_count,
	output int                                 pending
);
	import stoi_pkg::*;

	typedef enum logic [1:0] {SKIP_WS, SIGNS, DIGITS, DONE} parse_phase_e;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    base_ok;
	} parse_result_t;

	logic [CFG_W-1:0]   sym_lo;
	logic [CFG_W-1:0]   sym_hi;
	logic [BSIZE_W-1:0] radix;
	parse_phase_e       phase;
	logic               neg;
	logic [VAL_W-1:0]   acc;
	parse_result_t      expected_parses[$];

	function automatic logic [SYM_W-1:0] symbol(input int i);
		return (i < 8) ? sym_lo[8*i +: 8] : sym_hi[8*(i-8) +: 8];
	endfunction

	function automatic logic is_blank(input logic [SYM_W-1:0] c);
		return c inside {CHR_TAB, CHR_LF, CHR_VT, CHR_FF, CHR_CR, CHR_SPACE};
	endfunction

	// first matching symbol wins when the alphabet has duplicates
	function automatic int digit_index(input logic [SYM_W-1:0] c);
		int n;
		n = (radix > MAX_SYM) ? MAX_SYM : int'(radix);
		for (int i = 0; i < n; i++)
			if (symbol(i) == c) return i;
		return -1;
	endfunction

	function automatic logic alphabet_ok();
		logic [SYM_W-1:0] c;
		if (radix < MIN_BASE || radix > MAX_SYM) return 1'b0;
		for (int i = 0; i < int'(radix); i++) begin
			c = symbol(i);
			if (c == CHR_NUL || is_blank(c) || c == CHR_PLUS || c == CHR_MINUS) return 1'b0;
			for (int j = i + 1; j < int'(radix); j++)
				if (symbol(j) == c) return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int d;
		logic [VAL_W-1:0] mag;
		parse_result_t r;
		parse_result_t want;
		if (!arst_n) begin
			sym_lo = '0;
			sym_hi = '0;
			radix = '0;
			phase = SKIP_WS;
			neg = 1'b0;
			acc = '0;
			expected_parses.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_parses.size() == 0) begin
					$error("unexpected result: value %0d base_ok %0b", value, base_ok);
					fail_count++;
				end else begin
					want = expected_parses.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", $signed(want.value), value);
						fail_count++;
					end
					if (base_ok !== want.base_ok) begin
						$error("base_ok: expected %0b, got %0b", want.base_ok, base_ok);
						fail_count++;
					end
				end
			end

			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SYMBOLS_LO: sym_lo = cfg_wdata;
					REG_SYMBOLS_HI: sym_hi = cfg_wdata;
					REG_BASE_SIZE:  radix = cfg_wdata[BSIZE_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				if (phase == SKIP_WS && !is_blank(chr)) phase = SIGNS;
				if (phase == SIGNS) begin
					if (chr == CHR_MINUS) neg = !neg;
					else if (chr != CHR_PLUS) phase = DIGITS;
				end
				if (phase == DIGITS) begin
					d = digit_index(chr);
					if (d < 0) phase = DONE;
					else acc = acc * VAL_W'(radix) + VAL_W'(d);
				end
				if (last) begin
					// alphabet validity is judged with the config at the final item
					mag = neg ? (VAL_W'(0) - acc) : acc;
					r.base_ok = alphabet_ok();
					r.value = r.base_ok ? mag : '0;
					expected_parses.push_back(r);
					phase = SKIP_WS;
					neg = 1'b0;
					acc = '0;
				end
			end
			pending = expected_parses.size();
		end
	end

endmodule

[verif/tb_string_to_int_any_base.sv]
`timescale 1ns / 1ps

module tb_string_to_int_any_base;
	import stoi_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]          cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [SYM_W-1:0]          chr = '0;
	logic                      last = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VAL_W-1:0]   value;
	logic                      base_ok;

	int fail_count;
	int pending;

	// no idling on either side while set
	bit calm = 1'b0;

	logic [SYM_W-1:0] alphabet [16];
	int               nsym = 0;
	logic [SYM_W-1:0] text[$];
	// whitespace first (indices 0..5), then the other symbols an alphabet may not hold
	logic [SYM_W-1:0] bad_syms [9] = '{CHR_TAB, CHR_LF, CHR_VT, CHR_FF, CHR_CR, CHR_SPACE,
		CHR_PLUS, CHR_MINUS, CHR_NUL};

	string_to_int_any_base DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.chr       (chr),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.base_ok   (base_ok)
	);

	stoi_parse_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chr        (chr),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.base_ok    (base_ok),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 22);
	end

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_chr(input logic [SYM_W-1:0] c, input logic l);
		while (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		chr <= c;
		last <= l;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_text();
		foreach (text[k]) send_chr(text[k], k == text.size() - 1);
	endtask

	task automatic send_ascii(input string s);
		text = {};
		for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
		send_text();
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_alphabet(input logic [BSIZE_W-1:0] radix, input bit junk);
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = alphabet[k];
			hi[8*k +: 8] = alphabet[k+8];
		end
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SYMBOLS_LO;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= REG_SYMBOLS_HI;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_index <= REG_BASE_SIZE;
		// bits above the size field must be ignored
		cfg_wdata <= {junk ? (CFG_W-BSIZE_W)'({$urandom, $urandom}) : (CFG_W-BSIZE_W)'(0),
			radix};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		nsym = (radix > 16) ? 16 : int'(radix);
	endtask

	// sixteen distinct legal symbols
	task automatic fill_alphabet();
		logic [SYM_W-1:0] c;
		bit dup;
		for (int k = 0; k < 16; k++) begin
			do begin
				c = SYM_W'($urandom_range(1, 255));
				dup = c inside {CHR_TAB, CHR_LF, CHR_VT, CHR_FF, CHR_CR, CHR_SPACE,
					CHR_PLUS, CHR_MINUS};
				for (int j = 0; j < k; j++)
					if (alphabet[j] == c) dup = 1'b1;
			end while (dup);
			alphabet[k] = c;
		end
	endtask

	task automatic random_alphabet();
		int pick;
		int i;
		logic [BSIZE_W-1:0] radix;
		pick = $urandom_range(99);
		fill_alphabet();
		radix = BSIZE_W'($urandom_range(2, 16));
		if ($urandom_range(3) == 0) radix = $urandom_range(1) ? 5'd16 : 5'd2;
		if (pick < 10) begin
			for (int k = 0; k < 16; k++) alphabet[k] = SYM_W'(8'h30 + k);
			radix = 5'd10;
		end else if (pick < 20) begin
			i = $urandom_range(0, radix - 2);
			alphabet[$urandom_range(i + 1, radix - 1)] = alphabet[i];
		end else if (pick < 30) begin
			alphabet[$urandom_range(0, radix - 1)] = bad_syms[$urandom_range(0, 8)];
		end else if (pick < 40) begin
			radix = $urandom_range(1) ? BSIZE_W'($urandom_range(0, 1))
				: BSIZE_W'($urandom_range(17, 31));
			for (int k = 0; k < 16; k++) alphabet[k] = SYM_W'($urandom);
		end
		program_alphabet(radix, $urandom_range(1));
	endtask

	// mostly well-formed numbers; some with a break after the signs; some pure noise
	task automatic build_number();
		int kind;
		kind = $urandom_range(99);
		text = {};
		repeat ($urandom_range(0, 2)) text.push_back(bad_syms[$urandom_range(0, 5)]);
		if (kind < 85)
			repeat ($urandom_range(0, 3)) text.push_back($urandom_range(1) ? CHR_MINUS : CHR_PLUS);
		if (kind >= 70 && kind < 85) text.push_back(bad_syms[$urandom_range(0, 8)]);
		if (kind < 85)
			repeat ($urandom_range(1, 10))
				text.push_back(nsym > 0 ? alphabet[$urandom_range(0, nsym - 1)] : SYM_W'($urandom));
		if (kind >= 85 || $urandom_range(3) == 0)
			repeat ($urandom_range(1, 4)) text.push_back(SYM_W'($urandom));
	endtask

	initial begin
		int rand_items;
		int phase_end;
		rand_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset alphabet is empty, so the base is invalid
		send_ascii("7");

		wait_drain();
		for (int k = 0; k < 16; k++) alphabet[k] = SYM_W'(8'h30 + k);
		program_alphabet(5'd10, 1'b0);
		text = '{CHR_SPACE, CHR_TAB, CHR_LF, CHR_VT, CHR_FF, CHR_CR, CHR_MINUS, 8'h37};
		send_text();
		send_ascii("-+-3");
		send_ascii("- 5");
		text = '{8'h31, CHR_NUL, 8'h32};
		send_text();

		// alphabet changes between two items of one string
		send_chr("4", 1'b0);
		wait_drain();
		program_alphabet(5'd2, 1'b0);
		send_chr("1", 1'b1);

		// full 16-symbol alphabet, nine top digits wrap the accumulator
		wait_drain();
		for (int k = 0; k < 15; k++) alphabet[k] = SYM_W'(8'h61 + k);
		alphabet[15] = 8'hFF;
		program_alphabet(5'd16, 1'b1);
		text = '{CHR_PLUS};
		repeat (9) text.push_back(8'hFF);
		send_text();

		while (rand_items < 450) begin
			wait_drain();
			random_alphabet();
			phase_end = rand_items + $urandom_range(30, 60);
			while (rand_items < phase_end) begin
				calm = rand_items >= 180 && rand_items < 280;
				build_number();
				send_text();
				rand_items += text.size();
			end
		end
		calm = 1'b0;

		wait_drain();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("string_to_int_any_base verification clean");
		end else begin
			$display("string_to_int_any_base verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("string_to_int_any_base verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/stoi_pkg.sv
rtl/core/string_to_int_any_base.sv
rtl/core/stoi_checker.sv
verif/stoi_parse_checker.sv
verif/tb_string_to_int_any_base.sv
